### src/kgi_pkg.sv
package kgi_pkg;

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 48;
   localparam int MAX_KEYS  = 4096;
   localparam int CELL_CAP  = 8;
   localparam int MAX_HITS  = 64;

   localparam int NCELLS    = GRID_COLS * GRID_ROWS;
   localparam int NMEMBERS  = NCELLS * CELL_CAP;
   localparam int FRAC_BITS = 20;

   localparam int IDX_W  = 12;
   localparam int KEY_W  = $clog2(MAX_KEYS);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int CELL_W = $clog2(NCELLS);
   localparam int MEM_W  = $clog2(NMEMBERS);
   localparam int FILL_W = $clog2(CELL_CAP + 1);
   localparam int HIT_W  = $clog2(MAX_HITS + 1);
   localparam int COL_W  = $clog2(GRID_COLS);
   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam int CRD_W  = 17;
   localparam int OPA_W  = 19;
   localparam int OPB_W  = 17;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int KEY_DW = 16 + 16 + 3;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   localparam logic [1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [1:0] CSR_SCALE_X  = 2'd2;
   localparam logic [1:0] CSR_SCALE_Y  = 2'd3;

   typedef enum logic [2:0] {
      ST_STORED     = 3'd0,
      ST_OUTSIDE    = 3'd1,
      ST_CELL_FULL  = 3'd2,
      ST_STORE_FULL = 3'd3,
      ST_HIT        = 3'd4,
      ST_NONE       = 3'd5,
      ST_CUT        = 3'd6,
      ST_CLEARED    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      MUL_INS_X,
      MUL_INS_Y,
      MUL_LO_X,
      MUL_HI_X,
      MUL_LO_Y,
      MUL_HI_Y
   } mul_type;

   typedef enum logic [1:0] {
      IDX_ZERO,
      IDX_NEW,
      IDX_PEND
   } idx_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_CLR,
      S_INS_MX,
      S_INS_MY,
      S_INS_PY,
      S_INS_RD,
      S_INS_CHK,
      S_Q_M0,
      S_Q_M1,
      S_Q_M2,
      S_Q_M3,
      S_Q_P,
      S_Q_CHK,
      S_Q_FILL,
      S_Q_SLOT,
      S_Q_KEY,
      S_Q_TEST,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic       load;
      logic       key_wr;
      logic       mul_en;
      mul_type    mul_sel;
      logic       ins_rd;
      logic       ins_wr;
      logic       clr_step;
      logic       clr_all;
      logic       walk_init;
      logic       walk_next;
      logic       fill_rd;
      logic       mem_rd;
      logic       key_rd;
      logic       slot_inc;
      logic       hit_push;
      logic       emit;
      status_type emit_status;
      idx_type    emit_idx;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       store_full;
      logic       ins_ok;
      logic       fill_full;
      logic       q_empty;
      logic       slot_more;
      logic       walk_end;
      logic       hit;
      logic       hits_max;
      logic       have_pend;
      logic       out_free;
      logic       clr_done;
   } st_type;

endpackage

### src/kgi_req_if.sv
interface kgi_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [15:0]       pos_x;
   logic [15:0]       pos_y;
   logic [2:0]        level;
   logic [15:0]       radius;
   logic [2:0]        min_level;
   logic signed [3:0] max_level;

   modport source (output valid, mode, pos_x, pos_y, level, radius, min_level, max_level,
                   input ready);
   modport sink (input valid, mode, pos_x, pos_y, level, radius, min_level, max_level,
                 output ready);
endinterface

### src/kgi_rsp_if.sv
interface kgi_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] key_index;
   logic [2:0]  status;
   logic        last;

   modport source (output valid, key_index, status, last, input ready);
   modport sink (input valid, key_index, status, last, output ready);
endinterface

### src/kgi_csr_if.sv
interface kgi_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/kgi_ctrl.sv
module kgi_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  kgi_pkg::st_type  st,
   output kgi_pkg::cmd_type cmd
);

   kgi_pkg::state_type  state_ff, state_in;
   kgi_pkg::status_type status_ff, status_in;
   kgi_pkg::idx_type    idxsel_ff, idxsel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kgi_pkg::S_INIT;
         status_ff <= kgi_pkg::ST_NONE;
         idxsel_ff <= kgi_pkg::IDX_ZERO;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         idxsel_ff <= idxsel_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      idxsel_in       = idxsel_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.mul_sel     = kgi_pkg::MUL_INS_X;
      cmd.emit_status = status_ff;
      cmd.emit_idx    = idxsel_ff;
      case (state_ff)
         kgi_pkg::S_INIT: begin
            cmd.clr_step = 1'b1;
            if (st.clr_done) state_in = kgi_pkg::S_IDLE;
         end
         kgi_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kgi_pkg::S_DISPATCH;
            end
         end
         kgi_pkg::S_DISPATCH: begin
            case (st.mode)
               kgi_pkg::MODE_CLEAR: begin
                  cmd.clr_all = 1'b1;
                  state_in    = kgi_pkg::S_CLR;
               end
               kgi_pkg::MODE_INSERT: state_in = kgi_pkg::S_INS_MX;
               kgi_pkg::MODE_QUERY:  state_in = kgi_pkg::S_Q_M0;
               default:              state_in = kgi_pkg::S_IDLE;
            endcase
         end
         kgi_pkg::S_CLR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_done) begin
               status_in = kgi_pkg::ST_CLEARED;
               idxsel_in = kgi_pkg::IDX_ZERO;
               state_in  = kgi_pkg::S_FINAL;
            end
         end
         kgi_pkg::S_INS_MX: begin
            if (st.store_full) begin
               status_in = kgi_pkg::ST_STORE_FULL;
               idxsel_in = kgi_pkg::IDX_ZERO;
               state_in  = kgi_pkg::S_FINAL;
            end else begin
               cmd.key_wr  = 1'b1;
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = kgi_pkg::MUL_INS_X;
               state_in    = kgi_pkg::S_INS_MY;
            end
         end
         kgi_pkg::S_INS_MY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = kgi_pkg::MUL_INS_Y;
            state_in    = kgi_pkg::S_INS_PY;
         end
         kgi_pkg::S_INS_PY: state_in = kgi_pkg::S_INS_RD;
         kgi_pkg::S_INS_RD: begin
            idxsel_in = kgi_pkg::IDX_NEW;
            if (st.ins_ok) begin
               cmd.ins_rd = 1'b1;
               state_in   = kgi_pkg::S_INS_CHK;
            end else begin
               status_in = kgi_pkg::ST_OUTSIDE;
               state_in  = kgi_pkg::S_FINAL;
            end
         end
         kgi_pkg::S_INS_CHK: begin
            if (st.fill_full) begin
               status_in = kgi_pkg::ST_CELL_FULL;
            end else begin
               cmd.ins_wr = 1'b1;
               status_in  = kgi_pkg::ST_STORED;
            end
            state_in = kgi_pkg::S_FINAL;
         end
         kgi_pkg::S_Q_M0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = kgi_pkg::MUL_LO_X;
            state_in    = kgi_pkg::S_Q_M1;
         end
         kgi_pkg::S_Q_M1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = kgi_pkg::MUL_HI_X;
            state_in    = kgi_pkg::S_Q_M2;
         end
         kgi_pkg::S_Q_M2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = kgi_pkg::MUL_LO_Y;
            state_in    = kgi_pkg::S_Q_M3;
         end
         kgi_pkg::S_Q_M3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = kgi_pkg::MUL_HI_Y;
            state_in    = kgi_pkg::S_Q_P;
         end
         kgi_pkg::S_Q_P: state_in = kgi_pkg::S_Q_CHK;
         kgi_pkg::S_Q_CHK: begin
            if (st.q_empty) begin
               status_in = kgi_pkg::ST_NONE;
               idxsel_in = kgi_pkg::IDX_ZERO;
               state_in  = kgi_pkg::S_FINAL;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = kgi_pkg::S_Q_FILL;
            end
         end
         kgi_pkg::S_Q_FILL: begin
            cmd.fill_rd = 1'b1;
            state_in    = kgi_pkg::S_Q_SLOT;
         end
         kgi_pkg::S_Q_SLOT: begin
            if (st.slot_more) begin
               cmd.mem_rd = 1'b1;
               state_in   = kgi_pkg::S_Q_KEY;
            end else if (st.walk_end) begin
               if (st.have_pend) begin
                  status_in = kgi_pkg::ST_HIT;
                  idxsel_in = kgi_pkg::IDX_PEND;
               end else begin
                  status_in = kgi_pkg::ST_NONE;
                  idxsel_in = kgi_pkg::IDX_ZERO;
               end
               state_in = kgi_pkg::S_FINAL;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = kgi_pkg::S_Q_FILL;
            end
         end
         kgi_pkg::S_Q_KEY: begin
            cmd.key_rd = 1'b1;
            state_in   = kgi_pkg::S_Q_TEST;
         end
         kgi_pkg::S_Q_TEST: begin
            if (!st.hit) begin
               cmd.slot_inc = 1'b1;
               state_in     = kgi_pkg::S_Q_SLOT;
            end else if (st.hits_max) begin
               status_in = kgi_pkg::ST_CUT;
               idxsel_in = kgi_pkg::IDX_PEND;
               state_in  = kgi_pkg::S_FINAL;
            end else if (!st.have_pend || st.out_free) begin
               // The earlier hit leaves as a non-final transfer; this one is held back.
               cmd.hit_push = 1'b1;
               cmd.slot_inc = 1'b1;
               state_in     = kgi_pkg::S_Q_SLOT;
            end
         end
         kgi_pkg::S_FINAL: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = kgi_pkg::S_IDLE;
            end
         end
         default: state_in = kgi_pkg::S_INIT;
      endcase
   end

endmodule

### src/kgi_dpath.sv
module kgi_dpath (
   input  logic              clock,
   input  logic              reset,
   input  kgi_pkg::cmd_type   cmd,
   output kgi_pkg::st_type    st,
   input  logic [1:0]        req_mode,
   input  logic [15:0]       req_pos_x,
   input  logic [15:0]       req_pos_y,
   input  logic [2:0]        req_level,
   input  logic [15:0]       req_radius,
   input  logic [2:0]        req_min_level,
   input  logic signed [3:0] req_max_level,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [11:0]       rsp_key_index,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);

   localparam logic signed [kgi_pkg::CRD_W-1:0] COL_LIM = kgi_pkg::CRD_W'(kgi_pkg::GRID_COLS - 1);
   localparam logic signed [kgi_pkg::CRD_W-1:0] ROW_LIM = kgi_pkg::CRD_W'(kgi_pkg::GRID_ROWS - 1);

   // Item and configuration registers
   logic [1:0]        mode_ff;
   logic [15:0]       px_ff, py_ff, r_ff;
   logic [2:0]        lvl_ff, minl_ff;
   logic signed [3:0] maxl_ff;
   logic signed [15:0] ox_ff, oy_ff;
   logic [15:0]       cpx_ff, cpy_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         lvl_ff  <= req_level;
         r_ff    <= req_radius;
         minl_ff <= req_min_level;
         maxl_ff <= req_max_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff  <= '0;
         oy_ff  <= '0;
         cpx_ff <= 16'd6554;
         cpy_ff <= 16'd6554;
      end else if (csr_valid) begin
         case (csr_index)
            kgi_pkg::CSR_ORIGIN_X: ox_ff  <= csr_data;
            kgi_pkg::CSR_ORIGIN_Y: oy_ff  <= csr_data;
            kgi_pkg::CSR_SCALE_X:  cpx_ff <= csr_data;
            kgi_pkg::CSR_SCALE_Y:  cpy_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Shared multiplier: position offset times cells per pixel, Q.20 result.
   logic signed [kgi_pkg::OPA_W-1:0]  px19, py19, ox19, oy19, r19, mul_a;
   logic signed [kgi_pkg::OPB_W-1:0]  mul_b;
   logic signed [kgi_pkg::PROD_W-1:0] prod_ff;
   logic                              mul_vld_ff;
   kgi_pkg::mul_type                  mul_sel_ff;

   assign px19 = {3'b000, px_ff};
   assign py19 = {3'b000, py_ff};
   assign r19  = {3'b000, r_ff};
   assign ox19 = {{3{ox_ff[15]}}, ox_ff};
   assign oy19 = {{3{oy_ff[15]}}, oy_ff};

   always_comb begin
      case (cmd.mul_sel)
         kgi_pkg::MUL_INS_X: begin mul_a = px19 - ox19;       mul_b = {1'b0, cpx_ff}; end
         kgi_pkg::MUL_INS_Y: begin mul_a = py19 - oy19;       mul_b = {1'b0, cpy_ff}; end
         kgi_pkg::MUL_LO_X:  begin mul_a = px19 - ox19 - r19; mul_b = {1'b0, cpx_ff}; end
         kgi_pkg::MUL_HI_X:  begin mul_a = px19 - ox19 + r19; mul_b = {1'b0, cpx_ff}; end
         kgi_pkg::MUL_LO_Y:  begin mul_a = py19 - oy19 - r19; mul_b = {1'b0, cpy_ff}; end
         kgi_pkg::MUL_HI_Y:  begin mul_a = py19 - oy19 + r19; mul_b = {1'b0, cpy_ff}; end
         default:            begin mul_a = '0;                mul_b = '0;             end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) mul_vld_ff <= 1'b0;
      else       mul_vld_ff <= cmd.mul_en;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff    <= mul_a * mul_b;
         mul_sel_ff <= cmd.mul_sel;
      end
   end

   // Rounding (halves away from zero), floor and ceiling of the Q.20 product.
   logic                              p_neg;
   logic [kgi_pkg::PROD_W-1:0]        p_mag, rnd_sum;
   logic [kgi_pkg::CRD_W-1:0]         rnd_q;
   logic                              rnd_ok_x, rnd_ok_y;
   logic signed [kgi_pkg::PROD_W-1:0] flr_full, cel_full;
   logic signed [kgi_pkg::CRD_W-1:0]  flr, cel, lo_clamp, hi_x_clamp, hi_y_clamp;

   assign p_neg    = prod_ff[kgi_pkg::PROD_W-1];
   assign p_mag    = p_neg ? kgi_pkg::PROD_W'(-prod_ff) : kgi_pkg::PROD_W'(prod_ff);
   assign rnd_sum  = p_mag + (kgi_pkg::PROD_W'(1) << (kgi_pkg::FRAC_BITS - 1));
   assign rnd_q    = kgi_pkg::CRD_W'(rnd_sum[kgi_pkg::PROD_W-1:kgi_pkg::FRAC_BITS]);
   assign rnd_ok_x = (!p_neg || rnd_q == '0) && rnd_q < kgi_pkg::CRD_W'(kgi_pkg::GRID_COLS);
   assign rnd_ok_y = (!p_neg || rnd_q == '0) && rnd_q < kgi_pkg::CRD_W'(kgi_pkg::GRID_ROWS);
   assign flr_full = prod_ff >>> kgi_pkg::FRAC_BITS;
   assign cel_full = (prod_ff + $signed((kgi_pkg::PROD_W'(1) << kgi_pkg::FRAC_BITS) - 1))
                     >>> kgi_pkg::FRAC_BITS;
   assign flr        = flr_full[kgi_pkg::CRD_W-1:0];
   assign cel        = cel_full[kgi_pkg::CRD_W-1:0];
   assign lo_clamp   = (flr < 0) ? '0 : flr;
   assign hi_x_clamp = (cel > COL_LIM) ? COL_LIM : cel;
   assign hi_y_clamp = (cel > ROW_LIM) ? ROW_LIM : cel;

   logic [kgi_pkg::COL_W-1:0]        ins_col_ff;
   logic [kgi_pkg::ROW_W-1:0]        ins_row_ff;
   logic                             ins_okx_ff, ins_oky_ff;
   logic signed [kgi_pkg::CRD_W-1:0] lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff;

   always_ff @(posedge clock) begin
      if (mul_vld_ff) begin
         case (mul_sel_ff)
            kgi_pkg::MUL_INS_X: begin
               ins_col_ff <= rnd_q[kgi_pkg::COL_W-1:0];
               ins_okx_ff <= rnd_ok_x;
            end
            kgi_pkg::MUL_INS_Y: begin
               ins_row_ff <= rnd_q[kgi_pkg::ROW_W-1:0];
               ins_oky_ff <= rnd_ok_y;
            end
            kgi_pkg::MUL_LO_X: lo_x_ff <= lo_clamp;
            kgi_pkg::MUL_HI_X: hi_x_ff <= hi_x_clamp;
            kgi_pkg::MUL_LO_Y: lo_y_ff <= lo_clamp;
            kgi_pkg::MUL_HI_Y: hi_y_ff <= hi_y_clamp;
            default: ;
         endcase
      end
   end

   // Key store and key count
   logic [kgi_pkg::KEY_DW-1:0] key_mem [kgi_pkg::MAX_KEYS];
   logic [kgi_pkg::KEY_DW-1:0] key_rd_ff;
   logic [kgi_pkg::CNT_W-1:0]  key_count_ff;
   logic [kgi_pkg::KEY_W-1:0]  idx_ff, memb_rd_ff, cand_ff, pend_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_all) key_count_ff <= '0;
      else if (cmd.key_wr)      key_count_ff <= key_count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.key_wr) begin
         key_mem[key_count_ff[kgi_pkg::KEY_W-1:0]] <= {px_ff, py_ff, lvl_ff};
         idx_ff <= key_count_ff[kgi_pkg::KEY_W-1:0];
      end
      if (cmd.key_rd) begin
         key_rd_ff <= key_mem[memb_rd_ff];
         cand_ff   <= memb_rd_ff;
      end
   end

   // Grid: fill counts and member lists
   logic [kgi_pkg::FILL_W-1:0] fill_mem [kgi_pkg::NCELLS];
   logic [kgi_pkg::KEY_W-1:0]  memb_mem [kgi_pkg::NMEMBERS];
   logic [kgi_pkg::FILL_W-1:0] fill_rd_ff;
   logic [kgi_pkg::CELL_W-1:0] clr_ff, ins_cell, walk_cell;
   logic [kgi_pkg::COL_W-1:0]  col_ff;
   logic [kgi_pkg::ROW_W-1:0]  row_ff;
   logic [kgi_pkg::FILL_W-1:0] slot_ff;
   logic                       clr_done, row_end, walk_end;

   assign ins_cell  = kgi_pkg::CELL_W'(ins_col_ff) * kgi_pkg::CELL_W'(kgi_pkg::GRID_ROWS)
                      + kgi_pkg::CELL_W'(ins_row_ff);
   assign walk_cell = kgi_pkg::CELL_W'(col_ff) * kgi_pkg::CELL_W'(kgi_pkg::GRID_ROWS)
                      + kgi_pkg::CELL_W'(row_ff);
   assign clr_done  = clr_ff == kgi_pkg::CELL_W'(kgi_pkg::NCELLS - 1);
   assign row_end   = kgi_pkg::CRD_W'(row_ff) == hi_y_ff;
   assign walk_end  = row_end && kgi_pkg::CRD_W'(col_ff) == hi_x_ff;

   always_ff @(posedge clock) begin
      if (reset)              clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_done ? '0 : clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step)
         fill_mem[clr_ff] <= '0;
      else if (cmd.ins_wr)
         fill_mem[ins_cell] <= fill_rd_ff + 1'b1;
      if (cmd.ins_rd)
         fill_rd_ff <= fill_mem[ins_cell];
      else if (cmd.fill_rd)
         fill_rd_ff <= fill_mem[walk_cell];
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_wr)
         memb_mem[kgi_pkg::MEM_W'(ins_cell) * kgi_pkg::MEM_W'(kgi_pkg::CELL_CAP)
                  + kgi_pkg::MEM_W'(fill_rd_ff)] <= idx_ff;
      if (cmd.mem_rd)
         memb_rd_ff <= memb_mem[kgi_pkg::MEM_W'(walk_cell) * kgi_pkg::MEM_W'(kgi_pkg::CELL_CAP)
                                + kgi_pkg::MEM_W'(slot_ff)];
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         col_ff <= lo_x_ff[kgi_pkg::COL_W-1:0];
         row_ff <= lo_y_ff[kgi_pkg::ROW_W-1:0];
      end else if (cmd.walk_next) begin
         if (row_end) begin
            row_ff <= lo_y_ff[kgi_pkg::ROW_W-1:0];
            col_ff <= col_ff + 1'b1;
         end else begin
            row_ff <= row_ff + 1'b1;
         end
      end
      if (cmd.fill_rd)       slot_ff <= '0;
      else if (cmd.slot_inc) slot_ff <= slot_ff + 1'b1;
   end

   // Window and level test of the candidate key
   logic [15:0]               kx, ky;
   logic [2:0]                kl;
   logic [kgi_pkg::CRD_W-1:0] ex, ey, ex_abs, ey_abs;
   logic                      lvl_ok, hit;

   assign {kx, ky, kl} = key_rd_ff;
   assign ex     = {1'b0, kx} - {1'b0, px_ff};
   assign ey     = {1'b0, ky} - {1'b0, py_ff};
   assign ex_abs = ex[kgi_pkg::CRD_W-1] ? -ex : ex;
   assign ey_abs = ey[kgi_pkg::CRD_W-1] ? -ey : ey;
   assign lvl_ok = kl >= minl_ff && (maxl_ff[3] || kl <= maxl_ff[2:0]);
   assign hit    = lvl_ok && ex_abs < {1'b0, r_ff} && ey_abs < {1'b0, r_ff};

   logic [kgi_pkg::HIT_W-1:0] hit_cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         hit_cnt_ff <= '0;
      end else if (cmd.hit_push) begin
         hit_cnt_ff <= hit_cnt_ff + 1'b1;
         pend_ff    <= cand_ff;
      end
   end

   // Output register
   logic                       rsp_valid_ff, out_load, out_free;
   logic [kgi_pkg::IDX_W-1:0]  rsp_idx_ff;
   logic [2:0]                 rsp_status_ff;
   logic                       rsp_last_ff;
   logic [kgi_pkg::KEY_W-1:0]  emit_idx;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = cmd.emit || (cmd.hit_push && hit_cnt_ff != '0);

   always_comb begin
      case (cmd.emit_idx)
         kgi_pkg::IDX_NEW:  emit_idx = idx_ff;
         kgi_pkg::IDX_PEND: emit_idx = pend_ff;
         default:           emit_idx = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)         rsp_valid_ff <= 1'b0;
      else if (out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_idx_ff    <= kgi_pkg::IDX_W'(emit_idx);
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= 1'b1;
      end else if (out_load) begin
         rsp_idx_ff    <= kgi_pkg::IDX_W'(pend_ff);
         rsp_status_ff <= kgi_pkg::ST_HIT;
         rsp_last_ff   <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_index = rsp_idx_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   assign st.mode       = mode_ff;
   assign st.store_full = key_count_ff == kgi_pkg::CNT_W'(kgi_pkg::MAX_KEYS);
   assign st.ins_ok     = ins_okx_ff && ins_oky_ff;
   assign st.fill_full  = fill_rd_ff >= kgi_pkg::FILL_W'(kgi_pkg::CELL_CAP);
   assign st.q_empty    = lo_x_ff > hi_x_ff || lo_y_ff > hi_y_ff;
   assign st.slot_more  = slot_ff < fill_rd_ff;
   assign st.walk_end   = walk_end;
   assign st.hit        = hit;
   assign st.hits_max   = hit_cnt_ff == kgi_pkg::HIT_W'(kgi_pkg::MAX_HITS);
   assign st.have_pend  = hit_cnt_ff != '0;
   assign st.out_free   = out_free;
   assign st.clr_done   = clr_done;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register loaded while a result still waits");

   a_hit_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_push |-> hit_cnt_ff < kgi_pkg::HIT_W'(kgi_pkg::MAX_HITS))
      else $error("hit list grew past its limit");

   a_cell_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_wr |-> fill_rd_ff < kgi_pkg::FILL_W'(kgi_pkg::CELL_CAP))
      else $error("member written into a full cell");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_next |=> kgi_pkg::CRD_W'(col_ff) <= hi_x_ff)
      else $error("cell walk left the query window");

endmodule

### src/keypoint_grid_index_area_query.sv
// Keypoint grid index with square area query.
// req_ch carries one command per transfer: mode 0 clears the index, mode 1 inserts a
// keypoint, mode 2 queries a square window; mode 3 is dropped without a result.
// rsp_ch returns the results of a command in order; last marks the final one.
// csr_ch writes the grid origin and scale registers and is always ready; write it
// only while no command is in flight.
// Work per command, from the req_ch transfer to the final result:
//   insert: a key that lands outside the grid skips the fill-count update.
//   clear: one grid cell per cycle through the fill-count memory.
//   query: each cell walked reads its fill count, and each stored member
//   visited goes through the member memory and then the key store, one
//   registered read at a time.
// One command is worked at a time; the next req_ch transfer is taken once the
// previous command has queued its final result.
// After reset one pass clears the fill counts of all 3072 cells; req_ch stays
// not ready until it ends. The key store and member lists hold no reset value.
// A single output register sits on rsp_ch: while the receiver stalls, work goes
// on until the next result is ready, then waits for the register to drain.
module keypoint_grid_index_area_query (
   input logic       clock,
   input logic       reset,
   kgi_req_if.sink   req_ch,
   kgi_rsp_if.source rsp_ch,
   kgi_csr_if.sink   csr_ch
);

   kgi_pkg::cmd_type cmd;
   kgi_pkg::st_type  st;

   assign csr_ch.ready = 1'b1;

   kgi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   kgi_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_mode      (req_ch.mode),
      .req_pos_x     (req_ch.pos_x),
      .req_pos_y     (req_ch.pos_y),
      .req_level     (req_ch.level),
      .req_radius    (req_ch.radius),
      .req_min_level (req_ch.min_level),
      .req_max_level (req_ch.max_level),
      .csr_valid     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_key_index (rsp_ch.key_index),
      .rsp_status    (rsp_ch.status),
      .rsp_last      (rsp_ch.last)
   );

endmodule
